>>> hw/rtl/trd_pkg.sv
// ----------------------------------------------------------------------------
// trd_pkg: shared types and constants of the touch report decoder
// Result kinds, configuration record, result record and report layout values.
// ----------------------------------------------------------------------------
`default_nettype none

package trd_pkg;

   // report layout
   localparam int unsigned MAX_POINTS   = 5;
   localparam int unsigned RECORD_BYTES = 8;
   localparam int unsigned REC_SHIFT    = $clog2(RECORD_BYTES);

   // byte position counter, saturating
   localparam int unsigned POS_W        = 7;
   localparam logic [POS_W-1:0] POS_LIMIT = 7'd127;

   // status byte fields
   localparam int unsigned READY_BIT    = 7;
   localparam logic [7:0]  COUNT_MASK   = 8'h0F;

   // register map
   localparam int unsigned ADDR_W       = 4;
   localparam logic [1:0]  REG_ENABLE   = 2'd0;
   localparam logic [1:0]  REG_WIDTH    = 2'd1;
   localparam logic [1:0]  REG_HEIGHT   = 2'd2;
   localparam logic [1:0]  REG_CLAMP    = 2'd3;

   localparam logic [12:0] WIDTH_RESET  = 13'd800;
   localparam logic [12:0] HEIGHT_RESET = 13'd480;

   // result queue
   localparam int unsigned QDEPTH       = 4;
   localparam int unsigned QPTR_W       = $clog2(QDEPTH);
   localparam int unsigned QCNT_W       = $clog2(QDEPTH + 1);

   typedef enum logic [1:0] {
      KIND_POINT   = 2'd0,
      KIND_PRESS   = 2'd1,
      KIND_MOVE    = 2'd2,
      KIND_RELEASE = 2'd3
   } kind_type;

   typedef struct packed {
      logic        enable;
      logic [12:0] panel_width;
      logic [12:0] panel_height;
      logic        clamp_enable;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [11:0] x_pos;
      logic [11:0] y_pos;
      logic [3:0]  track_id;
      logic [2:0]  point_index;
      logic        final_res;
   } result_type;

   // clamp a coordinate to size minus one, a zero size clamps to zero
   function automatic logic [11:0] clamp_to(input logic [11:0] v, input logic [12:0] size);
      logic [12:0] lim;
      lim = (size == 13'd0) ? 13'd0 : size - 13'd1;
      return ({1'b0, v} > lim) ? lim[11:0] : v;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/trd_parse.sv
// ----------------------------------------------------------------------------
// trd_parse: report byte parser
// Tracks the frame position, assembles point records and forms up to two
// results per accepted byte: a point record and a press, move or release event.
// ----------------------------------------------------------------------------
`default_nettype none

module trd_parse (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_take,
   input  wire logic [7:0]          report_byte,
   input  wire logic                first_byte,
   input  wire logic                last_byte,
   input  trd_pkg::cfg_type         cfg,
   output logic                     slot0_valid,
   output logic                     slot1_valid,
   output trd_pkg::result_type      slot0,
   output trd_pkg::result_type      slot1
);

   logic [trd_pkg::POS_W-1:0] byte_pos_ff, byte_pos_in;
   logic [3:0]  pif_ff, pif_in;
   logic        ready_ff, ready_in;
   logic        touched_ff, touched_in;
   logic [3:0]  rec_id_ff, rec_id_in;
   logic [11:0] rec_x_ff, rec_x_in;
   logic [11:0] rec_y_ff, rec_y_in;
   logic [11:0] first_x_ff, first_x_in;
   logic [11:0] first_y_ff, first_y_in;
   logic [11:0] saved_x_ff, saved_x_in;
   logic [11:0] saved_y_ff, saved_y_in;

   logic [trd_pkg::POS_W-1:0] off_m1;
   logic [3:0]  rec_idx;
   logic [2:0]  rec_pos;
   logic [3:0]  cnt;
   logic [3:0]  pif_mid;
   logic        ready_mid;
   logic        pt_valid, ev_valid;
   trd_pkg::result_type pt, ev;
   logic [11:0] ev_x, ev_y;

   assign off_m1  = byte_pos_ff - trd_pkg::POS_W'(1);
   assign rec_idx = off_m1[trd_pkg::POS_W-1:trd_pkg::REC_SHIFT];
   assign rec_pos = off_m1[trd_pkg::REC_SHIFT-1:0];

   // frame decode for one item
   always_comb begin
      byte_pos_in = byte_pos_ff;
      pif_in      = pif_ff;
      ready_in    = ready_ff;
      touched_in  = touched_ff;
      rec_id_in   = rec_id_ff;
      rec_x_in    = rec_x_ff;
      rec_y_in    = rec_y_ff;
      first_x_in  = first_x_ff;
      first_y_in  = first_y_ff;
      saved_x_in  = saved_x_ff;
      saved_y_in  = saved_y_ff;
      pt_valid    = 1'b0;
      ev_valid    = 1'b0;
      cnt         = report_byte[3:0] & trd_pkg::COUNT_MASK[3:0];
      pif_mid     = pif_ff;
      ready_mid   = ready_ff;
      ev_x        = 12'd0;
      ev_y        = 12'd0;
      pt          = '0;
      ev          = '0;

      // status byte or record byte
      if (first_byte) begin
         if (cnt > 4'(trd_pkg::MAX_POINTS)) begin
            cnt = 4'(trd_pkg::MAX_POINTS);
         end
         ready_mid   = report_byte[trd_pkg::READY_BIT];
         pif_mid     = ready_mid ? cnt : 4'd0;
         first_x_in  = 12'd0;
         first_y_in  = 12'd0;
         byte_pos_in = trd_pkg::POS_W'(1);
      end else begin
         if ((byte_pos_ff != '0) && (rec_idx < pif_ff)) begin
            case (rec_pos)
               3'd0: rec_id_in = report_byte[7:4];
               3'd1: rec_x_in  = {rec_x_ff[11:8], report_byte};
               3'd2: rec_x_in  = {report_byte[3:0], rec_x_ff[7:0]};
               3'd3: rec_y_in  = {rec_y_ff[11:8], report_byte};
               3'd4: begin
                  rec_y_in = {report_byte[3:0], rec_y_ff[7:0]};
                  pt_valid = 1'b1;
                  if (rec_idx == 4'd0) begin
                     first_x_in = rec_x_ff;
                     first_y_in = rec_y_in;
                  end
               end
               default: ;
            endcase
         end
         if (byte_pos_ff < trd_pkg::POS_LIMIT) begin
            byte_pos_in = byte_pos_ff + trd_pkg::POS_W'(1);
         end
      end
      pif_in   = pif_mid;
      ready_in = ready_mid;

      pt.kind        = trd_pkg::KIND_POINT;
      pt.x_pos       = rec_x_ff;
      pt.y_pos       = rec_y_in;
      pt.track_id    = rec_id_ff;
      pt.point_index = rec_idx[2:0];

      // end of report: press or move from point 0, or release at the saved point
      if (last_byte) begin
         if (ready_mid) begin
            if (pif_mid == 4'd0) begin
               if (touched_ff) begin
                  touched_in = 1'b0;
                  ev_valid   = 1'b1;
                  ev.kind    = trd_pkg::KIND_RELEASE;
                  ev.x_pos   = saved_x_ff;
                  ev.y_pos   = saved_y_ff;
               end
            end else begin
               ev_x = first_x_in;
               ev_y = first_y_in;
               if (cfg.clamp_enable) begin
                  ev_x = trd_pkg::clamp_to(ev_x, cfg.panel_width);
                  ev_y = trd_pkg::clamp_to(ev_y, cfg.panel_height);
               end
               ev_valid   = 1'b1;
               ev.kind    = touched_ff ? trd_pkg::KIND_MOVE : trd_pkg::KIND_PRESS;
               ev.x_pos   = ev_x;
               ev.y_pos   = ev_y;
               touched_in = 1'b1;
               saved_x_in = ev_x;
               saved_y_in = ev_y;
            end
         end
         ready_in    = 1'b0;
         pif_in      = 4'd0;
         byte_pos_in = '0;
      end
   end

   // order the results: point first, event second
   always_comb begin
      slot0_valid     = pt_valid | ev_valid;
      slot1_valid     = pt_valid & ev_valid;
      slot0           = pt_valid ? pt : ev;
      slot1           = ev;
      slot0.final_res = ~slot1_valid;
      slot1.final_res = 1'b1;
   end

   // frame state, updated only on an item taken while enabled
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff <= '0;
         pif_ff      <= '0;
         ready_ff    <= 1'b0;
         touched_ff  <= 1'b0;
         rec_id_ff   <= '0;
         rec_x_ff    <= '0;
         rec_y_ff    <= '0;
         first_x_ff  <= '0;
         first_y_ff  <= '0;
         saved_x_ff  <= '0;
         saved_y_ff  <= '0;
      end else if (in_take && cfg.enable) begin
         byte_pos_ff <= byte_pos_in;
         pif_ff      <= pif_in;
         ready_ff    <= ready_in;
         touched_ff  <= touched_in;
         rec_id_ff   <= rec_id_in;
         rec_x_ff    <= rec_x_in;
         rec_y_ff    <= rec_y_in;
         first_x_ff  <= first_x_in;
         first_y_ff  <= first_y_in;
         saved_x_ff  <= saved_x_in;
         saved_y_ff  <= saved_y_in;
      end
   end

   // a second result is always an event that follows a point record
   assert property (@(posedge clock) disable iff (reset)
      slot1_valid |-> (slot0.kind == trd_pkg::KIND_POINT && last_byte))
      else $error("second result without a point record before it");

   // the point count never exceeds the limit
   assert property (@(posedge clock) disable iff (reset)
      pif_ff <= 4'(trd_pkg::MAX_POINTS))
      else $error("point count above limit");

   // outside a frame no point count is held
   assert property (@(posedge clock) disable iff (reset)
      !ready_ff |-> pif_ff == 4'd0)
      else $error("point count held without ready status");

endmodule

`default_nettype wire

>>> hw/rtl/trd_out_fifo.sv
// ----------------------------------------------------------------------------
// trd_out_fifo: result queue
// Takes up to two results a cycle and, while out_stall is low, hands them out
// one a cycle; asks the input to stall while fewer than two entries are free.
// ----------------------------------------------------------------------------
`default_nettype none

module trd_out_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push0,
   input  wire logic                push1,
   input  trd_pkg::result_type      data0,
   input  trd_pkg::result_type      data1,
   output logic                     full,
   output logic                     out_valid,
   input  wire logic                out_stall,
   output trd_pkg::result_type      out_data
);

   trd_pkg::result_type mem_ff [trd_pkg::QDEPTH];
   logic [trd_pkg::QPTR_W-1:0] wptr_ff, wptr_in;
   logic [trd_pkg::QPTR_W-1:0] rptr_ff, rptr_in;
   logic [trd_pkg::QCNT_W-1:0] count_ff, count_in;
   logic [trd_pkg::QPTR_W-1:0] wptr_next;
   logic pop;
   logic [1:0] npush;

   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rptr_ff];
   assign full      = (count_ff > trd_pkg::QCNT_W'(trd_pkg::QDEPTH - 2));
   assign pop       = out_valid & ~out_stall;
   assign npush     = {1'b0, push0} + {1'b0, push1};
   assign wptr_next = wptr_ff + trd_pkg::QPTR_W'(1);

   // pointer and fill count
   always_comb begin
      wptr_in  = wptr_ff + trd_pkg::QPTR_W'(npush);
      rptr_in  = rptr_ff + trd_pkg::QPTR_W'(pop);
      count_in = count_ff + trd_pkg::QCNT_W'(npush) - trd_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push0) begin
         mem_ff[wptr_ff] <= data0;
      end
      if (push1) begin
         mem_ff[wptr_next] <= data1;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= trd_pkg::QCNT_W'(trd_pkg::QDEPTH))
      else $error("result queue overfilled");

   assert property (@(posedge clock) disable iff (reset)
      push1 |-> push0)
      else $error("second result pushed without first");

   assert property (@(posedge clock) disable iff (reset)
      (push0 || push1) |-> !full)
      else $error("push into queue without room for two");

endmodule

`default_nettype wire

>>> hw/rtl/touch_report_decoder.sv
// ----------------------------------------------------------------------------
// touch_report_decoder: touch controller coordinate report decoder
// Parses report bytes into point records and press, move or release events.
// ----------------------------------------------------------------------------
// One report byte is taken per clock cycle unless stalled. Each byte is
// decoded in the cycle it is taken and its results (none, one, or a point
// record followed by an event) go into a four-entry result queue that hands
// out one result a cycle unless stalled. req_stall rises while the queue has
// fewer than two free entries, so the sustained rate is one byte a cycle
// except where a byte gives two results. Registers are to be written through
// the APB-style port only while no item is in flight; this is not enforced.
`default_nettype none

module touch_report_decoder (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // report bytes
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [7:0]                   req_report_byte,
   input  wire logic                         req_first_byte,
   input  wire logic                         req_last_byte,
   // results
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [1:0]                        rsp_kind,
   output logic [11:0]                       rsp_x_pos,
   output logic [11:0]                       rsp_y_pos,
   output logic [3:0]                        rsp_track_id,
   output logic [2:0]                        rsp_point_index,
   output logic                              rsp_final_res,
   // configuration
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [trd_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [31:0]                  pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   trd_pkg::cfg_type    cfg_ff, cfg_in;
   trd_pkg::result_type slot0, slot1, head;
   logic                slot0_valid, slot1_valid;
   logic                full;
   logic                in_take;
   logic                cfg_write;
   logic [1:0]          reg_sel;

   assign pready    = 1'b1;
   assign reg_sel   = paddr[3:2];
   assign cfg_write = psel & penable & pwrite & pready;
   assign req_stall = full;
   assign in_take   = req_valid & ~req_stall;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         unique case (reg_sel)
            trd_pkg::REG_ENABLE: cfg_in.enable       = pwdata[0];
            trd_pkg::REG_WIDTH:  cfg_in.panel_width  = pwdata[12:0];
            trd_pkg::REG_HEIGHT: cfg_in.panel_height = pwdata[12:0];
            trd_pkg::REG_CLAMP:  cfg_in.clamp_enable = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable       <= 1'b0;
         cfg_ff.panel_width  <= trd_pkg::WIDTH_RESET;
         cfg_ff.panel_height <= trd_pkg::HEIGHT_RESET;
         cfg_ff.clamp_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register read back
   always_comb begin
      prdata = 32'd0;
      unique case (reg_sel)
         trd_pkg::REG_ENABLE: prdata = {31'd0, cfg_ff.enable};
         trd_pkg::REG_WIDTH:  prdata = {19'd0, cfg_ff.panel_width};
         trd_pkg::REG_HEIGHT: prdata = {19'd0, cfg_ff.panel_height};
         trd_pkg::REG_CLAMP:  prdata = {31'd0, cfg_ff.clamp_enable};
         default: prdata = 32'd0;
      endcase
   end

   trd_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .in_take     (in_take),
      .report_byte (req_report_byte),
      .first_byte  (req_first_byte),
      .last_byte   (req_last_byte),
      .cfg         (cfg_ff),
      .slot0_valid (slot0_valid),
      .slot1_valid (slot1_valid),
      .slot0       (slot0),
      .slot1       (slot1)
   );

   trd_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push0     (in_take & cfg_ff.enable & slot0_valid),
      .push1     (in_take & cfg_ff.enable & slot1_valid),
      .data0     (slot0),
      .data1     (slot1),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (head)
   );

   assign rsp_kind        = head.kind;
   assign rsp_x_pos       = head.x_pos;
   assign rsp_y_pos       = head.y_pos;
   assign rsp_track_id    = head.track_id;
   assign rsp_point_index = head.point_index;
   assign rsp_final_res   = head.final_res;

endmodule

`default_nettype wire

>>> tb/sv/touch_report_decoder_checker.sv
// ----------------------------------------------------------------------------
// touch_report_decoder_checker: result checker of the touch report decoder
// Follows the configuration port and the report byte channel, decodes each
// accepted item into the point records and touch events it should give, and
// compares every accepted result with the oldest one still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module touch_report_decoder_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic                        req_stall,
   input  wire logic [7:0]                  req_report_byte,
   input  wire logic                        req_first_byte,
   input  wire logic                        req_last_byte,
   input  wire logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   input  wire logic [1:0]                  rsp_kind,
   input  wire logic [11:0]                 rsp_x_pos,
   input  wire logic [11:0]                 rsp_y_pos,
   input  wire logic [3:0]                  rsp_track_id,
   input  wire logic [2:0]                  rsp_point_index,
   input  wire logic                        rsp_final_res,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [trd_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [31:0]                 pwdata,
   input  wire logic                        pready,
   output int                               fail_count,
   output int                               results_due
);

   // register copy
   trd_pkg::cfg_type  cfg;

   // frame decode state
   logic [trd_pkg::POS_W-1:0] byte_at;
   logic [3:0]        frame_points;
   logic              frame_ok;
   logic              is_touched;
   logic [3:0]        cur_id;
   logic [11:0]       cur_x;
   logic [11:0]       cur_y;
   logic [11:0]       lead_x;
   logic [11:0]       lead_y;
   logic [11:0]       last_x;
   logic [11:0]       last_y;

   trd_pkg::result_type decoded_results[$];
   int                errors = 0;

   // limit a coordinate to size minus one; sizes past 4096 leave it alone
   function automatic logic [11:0] clip_coord(input logic [11:0] v, input logic [12:0] size);
      logic [12:0] top_val;
      if (size == 13'd0) return 12'd0;
      top_val = size - 13'd1;
      if (top_val[12] || v <= top_val[11:0]) return v;
      return top_val[11:0];
   endfunction

   // decode one report byte into the results it gives
   task automatic decode_byte(input logic [7:0] b, input logic first, input logic last);
      trd_pkg::result_type made[2];
      int          n;
      int          cnt;
      int          rel;
      int          idx;
      int          sub;
      logic [11:0] ex;
      logic [11:0] ey;
      n = 0;
      if (!cfg.enable) return;

      if (first) begin
         // status byte
         cnt = int'(b & trd_pkg::COUNT_MASK);
         frame_ok = b[trd_pkg::READY_BIT];
         if (cnt > trd_pkg::MAX_POINTS) cnt = trd_pkg::MAX_POINTS;
         frame_points = frame_ok ? 4'(cnt) : 4'd0;
         lead_x  = 12'd0;
         lead_y  = 12'd0;
         byte_at = trd_pkg::POS_W'(1);
      end else begin
         // record bytes
         if (byte_at >= trd_pkg::POS_W'(1)) begin
            rel = int'(byte_at) - 1;
            idx = rel / trd_pkg::RECORD_BYTES;
            sub = rel % trd_pkg::RECORD_BYTES;
            if (idx < int'(frame_points)) begin
               case (sub)
                  0: cur_id = b[7:4];
                  1: cur_x[7:0] = b;
                  2: cur_x[11:8] = b[3:0];
                  3: cur_y[7:0] = b;
                  4: begin
                     cur_y[11:8] = b[3:0];
                     if (idx == 0) begin
                        lead_x = cur_x;
                        lead_y = cur_y;
                     end
                     made[n] = '{kind: trd_pkg::KIND_POINT, x_pos: cur_x, y_pos: cur_y,
                                 track_id: cur_id, point_index: 3'(idx), final_res: 1'b0};
                     n++;
                  end
                  default: ;
               endcase
            end
         end
         if (byte_at < trd_pkg::POS_LIMIT) byte_at = byte_at + trd_pkg::POS_W'(1);
      end

      if (last) begin
         // end of report: touch event from point 0, or release at the last position
         if (frame_ok) begin
            if (frame_points == 4'd0) begin
               if (is_touched) begin
                  is_touched = 1'b0;
                  made[n] = '{kind: trd_pkg::KIND_RELEASE, x_pos: last_x, y_pos: last_y,
                              track_id: 4'd0, point_index: 3'd0, final_res: 1'b0};
                  n++;
               end
            end else begin
               ex = lead_x;
               ey = lead_y;
               if (cfg.clamp_enable) begin
                  ex = clip_coord(ex, cfg.panel_width);
                  ey = clip_coord(ey, cfg.panel_height);
               end
               made[n] = '{kind: is_touched ? trd_pkg::KIND_MOVE : trd_pkg::KIND_PRESS,
                           x_pos: ex, y_pos: ey,
                           track_id: 4'd0, point_index: 3'd0, final_res: 1'b0};
               n++;
               is_touched = 1'b1;
               last_x = ex;
               last_y = ey;
            end
         end
         frame_ok     = 1'b0;
         frame_points = 4'd0;
         byte_at      = '0;
      end

      if (n > 0) made[n-1].final_res = 1'b1;
      for (int i = 0; i < n; i++) decoded_results.push_back(made[i]);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // compare one accepted result with the oldest one due
   task automatic check_result();
      trd_pkg::result_type due;
      if (decoded_results.size() == 0) begin
         $display("%0t: result with none due, kind %0d x %0d y %0d id %0d index %0d",
                  $time, rsp_kind, rsp_x_pos, rsp_y_pos, rsp_track_id, rsp_point_index);
         errors++;
         return;
      end
      due = decoded_results.pop_front();
      check_field("kind", int'(due.kind), int'(rsp_kind));
      check_field("x_pos", int'(due.x_pos), int'(rsp_x_pos));
      check_field("y_pos", int'(due.y_pos), int'(rsp_y_pos));
      check_field("track_id", int'(due.track_id), int'(rsp_track_id));
      check_field("point_index", int'(due.point_index), int'(rsp_point_index));
      check_field("final_res", int'(due.final_res), int'(rsp_final_res));
   endtask

   // sample all channels at each edge
   always @(posedge clock) begin
      if (reset) begin
         cfg.enable       = 1'b0;
         cfg.panel_width  = trd_pkg::WIDTH_RESET;
         cfg.panel_height = trd_pkg::HEIGHT_RESET;
         cfg.clamp_enable = 1'b1;
         byte_at      = '0;
         frame_points = 4'd0;
         frame_ok     = 1'b0;
         is_touched   = 1'b0;
         cur_id       = 4'd0;
         cur_x        = 12'd0;
         cur_y        = 12'd0;
         lead_x       = 12'd0;
         lead_y       = 12'd0;
         last_x       = 12'd0;
         last_y       = 12'd0;
         decoded_results.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               trd_pkg::REG_ENABLE: cfg.enable       = pwdata[0];
               trd_pkg::REG_WIDTH:  cfg.panel_width  = pwdata[12:0];
               trd_pkg::REG_HEIGHT: cfg.panel_height = pwdata[12:0];
               trd_pkg::REG_CLAMP:  cfg.clamp_enable = pwdata[0];
               default: ;
            endcase
         end
         // a result taken now always comes from an earlier item
         if (rsp_valid && !rsp_stall)
            check_result();
         if (req_valid && !req_stall)
            decode_byte(req_report_byte, req_first_byte, req_last_byte);
      end
      fail_count  <= errors;
      results_due <= decoded_results.size();
   end

endmodule

>>> tb/sv/touch_report_decoder_tb.sv
// ----------------------------------------------------------------------------
// touch_report_decoder_tb: testbench top of the touch report decoder
// Sends directed and random coordinate reports under several panel settings,
// paces both channels with random gaps and gives the verdict of the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module touch_report_decoder_tb;

   logic                clock = 1'b0;
   logic                reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [7:0]          req_report_byte = 8'd0;
   logic                req_first_byte = 1'b0;
   logic                req_last_byte = 1'b0;

   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_kind;
   logic [11:0]         rsp_x_pos;
   logic [11:0]         rsp_y_pos;
   logic [3:0]          rsp_track_id;
   logic [2:0]          rsp_point_index;
   logic                rsp_final_res;

   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [trd_pkg::ADDR_W-1:0] paddr = '0;
   logic [31:0]         pwdata = 32'd0;
   logic [31:0]         prdata;
   logic                pready;

   int                  fail_count;
   int                  results_due;
   int                  items_sent = 0;
   bit                  req_quiet = 1'b0;
   bit                  rsp_quiet = 1'b0;
   int                  stall_left = 0;

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   touch_report_decoder uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_report_byte (req_report_byte),
      .req_first_byte  (req_first_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_x_pos       (rsp_x_pos),
      .rsp_y_pos       (rsp_y_pos),
      .rsp_track_id    (rsp_track_id),
      .rsp_point_index (rsp_point_index),
      .rsp_final_res   (rsp_final_res),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   touch_report_decoder_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_report_byte (req_report_byte),
      .req_first_byte  (req_first_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_x_pos       (rsp_x_pos),
      .rsp_y_pos       (rsp_y_pos),
      .rsp_track_id    (rsp_track_id),
      .rsp_point_index (rsp_point_index),
      .rsp_final_res   (rsp_final_res),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .pready          (pready),
      .fail_count      (fail_count),
      .results_due     (results_due)
   );

   // result side: random stall after each accepted result
   always @(posedge clock) begin : rsp_pace
      int hold;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end else if (rsp_valid && !rsp_stall) begin
         hold = rsp_quiet ? 0 : $urandom_range(0, 15);
         stall_left <= hold;
         rsp_stall  <= (hold != 0);
      end
   end

   // one report byte, after a random gap
   task automatic send_item(input logic [7:0] b, input logic first, input logic last);
      int gap;
      if ($urandom_range(0, 29) == 0) req_quiet = !req_quiet;
      gap = req_quiet ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_report_byte <= b;
      req_first_byte  <= first;
      req_last_byte   <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // register write: setup then access
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // let every due result drain and the decoder settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [12:0] draw_panel_size();
      if ($urandom_range(0, 3) == 0) return 13'($urandom_range(1, 4096));
      return 13'($urandom_range(200, 1300));
   endfunction

   // mostly well formed report with random content
   task automatic send_frame();
      int         cnt;
      int         nrec;
      int         body;
      int         stop_at;
      logic [7:0] status;
      if ($urandom_range(0, 14) == 0) rsp_quiet = !rsp_quiet;
      cnt    = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 15) : $urandom_range(0, 5);
      status = {($urandom_range(0, 9) != 0), 3'($urandom), 4'(cnt)};
      nrec   = !status[7] ? 0 : (cnt > trd_pkg::MAX_POINTS) ? trd_pkg::MAX_POINTS : cnt;
      body   = nrec * trd_pkg::RECORD_BYTES;
      case ($urandom_range(0, 9))
         0: stop_at = $urandom_range(0, body);
         1: stop_at = body + $urandom_range(1, 12);
         2: stop_at = (nrec > 0) ? (nrec - 1) * trd_pkg::RECORD_BYTES + 5 : 0;
         default: stop_at = body;
      endcase
      // rare overlong report runs the byte counter into saturation
      if ($urandom_range(0, 59) == 0) stop_at = body + 130;
      send_item(status, 1'b1, stop_at == 0);
      for (int i = 1; i <= stop_at; i++)
         send_item(8'($urandom), 1'b0, i == stop_at);
   endtask

   // loose bytes with random markers
   task automatic send_noise();
      int len;
      len = $urandom_range(1, 6);
      repeat (len)
         send_item(8'($urandom), $urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0);
   endtask

   // stimulus and verdict
   initial begin
      logic [12:0] w;
      logic [12:0] h;
      logic        c;
      logic        en;
      int          quota;
      int          start;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // ignored while disabled
      send_item(8'h81, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      wait_idle();
      csr_write(trd_pkg::REG_ENABLE, 32'd1);

      // bytes outside any report
      send_item(8'hA5, 1'b0, 1'b0);
      send_item(8'h5A, 1'b0, 1'b1);

      // full-scale point with last on its final coordinate byte: point then press
      send_item(8'h81, 1'b1, 1'b0);
      send_item(8'hF7, 1'b0, 1'b0);
      send_item(8'hFF, 1'b0, 1'b0);
      send_item(8'hFF, 1'b0, 1'b0);
      send_item(8'hFF, 1'b0, 1'b0);
      send_item(8'hFF, 1'b0, 1'b1);

      // status and last together with zero points: release
      send_item(8'h80, 1'b1, 1'b1);

      // not ready
      send_item(8'h05, 1'b1, 1'b0);
      send_item(8'h12, 1'b0, 1'b1);

      // count above the limit, report ends at once: press at cleared point 0
      send_item(8'h8F, 1'b1, 1'b1);

      // two points of zero and mixed coordinates, then a move
      send_item(8'h82, 1'b1, 1'b0);
      send_item(8'h30, 1'b0, 1'b0);
      repeat (7) send_item(8'h00, 1'b0, 1'b0);
      send_item(8'h4C, 1'b0, 1'b0);
      send_item(8'h34, 1'b0, 1'b0);
      send_item(8'h12, 1'b0, 1'b0);
      send_item(8'h78, 1'b0, 1'b0);
      send_item(8'h06, 1'b0, 1'b1);

      // random phases, each under its own settings
      for (int p = 0; p < 12; p++) begin
         wait_idle();
         case (p)
            0: begin w = 13'd1;    h = 13'd1;    c = 1'b1; end
            1: begin w = 13'd4096; h = 13'd4096; c = 1'b1; end
            2: begin w = 13'd0;    h = 13'd8191; c = 1'b1; end
            3: begin w = 13'd800;  h = 13'd480;  c = 1'b0; end
            default: begin
               w = draw_panel_size();
               h = draw_panel_size();
               c = 1'($urandom_range(0, 1));
            end
         endcase
         en = (p != 5);
         csr_write(trd_pkg::REG_ENABLE, {31'd0, en});
         csr_write(trd_pkg::REG_WIDTH, {19'd0, w});
         csr_write(trd_pkg::REG_HEIGHT, {19'd0, h});
         csr_write(trd_pkg::REG_CLAMP, {31'd0, c});
         quota = en ? 135 : 40;
         start = items_sent;
         while (items_sent - start < quota) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            else send_frame();
         end
      end

      wait_idle();
      repeat (16) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // run time limit
   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
